@@ rtl/strm_pkg.sv @@
// shared constants, op codes and width helpers for the range maximum segment tree
package strm_pkg;

  localparam int CMD_W = 2;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 11;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam int OP_KIND_W = 2;

  typedef enum logic [OP_KIND_W-1:0] {
    OP_CLEAR,
    OP_WRITE,
    OP_BUILD,
    OP_QUERY
  } op_kind_t;

  localparam int QUEUE_DEPTH = 2;

  function automatic int eff_width(input int vw);
    return (vw < VALUE_W) ? vw : VALUE_W;
  endfunction

  function automatic int op_width(input int leaves, input int vw);
    return OP_KIND_W + 2 * $clog2(2 * leaves + 1) + eff_width(vw) + 1;
  endfunction

endpackage

@@ rtl/strm_if.sv @@
// command and result channel interfaces
interface strm_item_if;
  import strm_pkg::*;

  logic valid;
  logic ready;
  logic [CMD_W-1:0] cmd;
  logic signed [VALUE_W-1:0] value;
  logic last;
  logic [INDEX_W-1:0] left;
  logic [INDEX_W-1:0] right;

  modport source (output valid, output cmd, output value, output last, output left,
                  output right, input ready);
  modport sink (input valid, input cmd, input value, input last, input left, input right,
                output ready);
endinterface

interface strm_result_if;
  import strm_pkg::*;

  logic valid;
  logic ready;
  logic signed [VALUE_W-1:0] max_value;
  logic empty_res;

  modport source (output valid, output max_value, output empty_res, input ready);
  modport sink (input valid, input max_value, input empty_res, output ready);
endinterface

@@ rtl/strm_front.sv @@
// front end: accepts commands, tracks the load position and turns commands into tree ops
module strm_front #(
  parameter int LEAVES = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  strm_item_if.sink item,
  input  logic init_done,
  output logic q_valid,
  input  logic q_ready,
  output logic [strm_pkg::op_width(LEAVES, VALUE_WIDTH)-1:0] q_data
);
  import strm_pkg::*;

  localparam int EW = eff_width(VALUE_WIDTH);
  localparam int AW = $clog2(2 * LEAVES + 1);
  localparam int PW = $clog2(LEAVES + 1);

  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  op_kind_t kind;
  logic push;
  logic flag;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [31:0] left_c;
  logic [31:0] right_c;
  logic pos_free;
  logic take;

  assign item.ready = init_done && q_ready;
  assign take = item.valid && item.ready;
  assign pos_free = 32'(pos) < 32'(LEAVES);

  // clamp query bounds to the leaf count
  assign left_c = (32'(item.left) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(item.left);
  assign right_c = (32'(item.right) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(item.right);

  always_comb begin
    kind = OP_CLEAR;
    push = 1'b0;
    flag = 1'b0;
    pos_next = pos;
    addr_a = AW'(32'(LEAVES) + left_c);
    addr_b = AW'(32'(LEAVES) + right_c);
    unique case (item.cmd)
      CMD_CLEAR: begin
        kind = OP_CLEAR;
        push = 1'b1;
        pos_next = '0;
      end
      CMD_LOAD: begin
        flag = item.last;
        if (pos_free) begin
          kind = OP_WRITE;
          push = 1'b1;
          addr_a = AW'(32'(LEAVES) + 32'(pos));
          pos_next = pos + PW'(1);
        end else begin
          kind = OP_BUILD;
          push = item.last;
        end
      end
      CMD_QUERY: begin
        kind = OP_QUERY;
        push = 1'b1;
        flag = !(item.left < item.right);
        if (flag) begin
          addr_b = addr_a;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign q_valid = item.valid && init_done && push;
  assign q_data = {kind, addr_a, addr_b, item.value[EW-1:0], flag};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (take) begin
      pos <= pos_next;
    end
  end

endmodule

@@ rtl/strm_queue.sv @@
// short op queue between front and back end
module strm_queue #(
  parameter int WIDTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import strm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_data = entry[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/strm_back.sv @@
// back end: node memory, clear sweep, tree build and range climb
module strm_back #(
  parameter int LEAVES = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  logic [strm_pkg::op_width(LEAVES, VALUE_WIDTH)-1:0] q_data,
  output logic init_done,
  strm_result_if.source result
);
  import strm_pkg::*;

  localparam int EW = eff_width(VALUE_WIDTH);
  localparam int AW = $clog2(2 * LEAVES + 1);
  localparam int NW = $clog2(2 * LEAVES);
  localparam int LW = $clog2(LEAVES);
  localparam logic signed [EW-1:0] NEG = {1'b1, {(EW - 1){1'b0}}};

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_BUILD_RD,
    S_BUILD_WR,
    S_CLIMB,
    S_RESULT
  } state_t;

  state_t state;

  logic signed [EW-1:0] node_mem [2 * LEAVES];
  logic signed [EW-1:0] rdata_a;
  logic signed [EW-1:0] rdata_b;
  logic [NW-1:0] raddr_a;
  logic [NW-1:0] raddr_b;
  logic [NW-1:0] waddr;
  logic we;
  logic signed [EW-1:0] wdata;

  logic [NW-1:0] sweep;
  logic [LW-1:0] bi;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic [AW-1:0] hi_dec;
  logic va;
  logic vb;
  logic signed [EW-1:0] acc;
  logic signed [EW-1:0] acc_next;
  logic signed [EW-1:0] max_a;
  logic signed [EW-1:0] cand_a;
  logic signed [EW-1:0] cand_b;
  logic signed [EW-1:0] child_max;
  logic empty_q;

  logic [OP_KIND_W-1:0] op_code;
  op_kind_t op_kind;
  logic [AW-1:0] op_a;
  logic [AW-1:0] op_b;
  logic signed [EW-1:0] op_value;
  logic op_flag;
  logic pop;
  logic climbing;
  logic out_free;

  assign {op_code, op_a, op_b, op_value, op_flag} = q_data;
  assign op_kind = op_kind_t'(op_code);

  assign q_ready = state == S_IDLE;
  assign pop = q_valid && q_ready;
  assign climbing = lo < hi;
  assign hi_dec = hi - AW'(1);
  assign out_free = !result.valid || result.ready;

  assign cand_a = va ? rdata_a : NEG;
  assign cand_b = vb ? rdata_b : NEG;
  assign max_a = (cand_a > acc) ? cand_a : acc;
  assign acc_next = (cand_b > max_a) ? cand_b : max_a;
  assign child_max = (rdata_a > rdata_b) ? rdata_a : rdata_b;

  always_comb begin
    raddr_a = {bi, 1'b0};
    raddr_b = {bi, 1'b1};
    if (state == S_CLIMB) begin
      raddr_a = lo[NW-1:0];
      raddr_b = hi_dec[NW-1:0];
    end
    we = 1'b0;
    waddr = sweep;
    wdata = NEG;
    unique case (state)
      S_SWEEP: begin
        we = 1'b1;
      end
      S_BUILD_WR: begin
        we = 1'b1;
        waddr = NW'(bi);
        wdata = child_max;
      end
      S_IDLE: begin
        if (pop && op_kind == OP_WRITE) begin
          we = 1'b1;
          waddr = op_a[NW-1:0];
          wdata = op_value;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      node_mem[waddr] <= wdata;
    end
    rdata_a <= node_mem[raddr_a];
    rdata_b <= node_mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      sweep <= '0;
      init_done <= 1'b0;
      result.valid <= 1'b0;
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_RESULT) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep <= sweep + NW'(1);
          if (sweep == NW'(2 * LEAVES - 1)) begin
            state <= S_IDLE;
            init_done <= 1'b1;
          end
        end
        S_IDLE: begin
          if (pop) begin
            unique case (op_kind)
              OP_CLEAR: begin
                sweep <= '0;
                state <= S_SWEEP;
              end
              OP_WRITE: begin
                if (op_flag) begin
                  bi <= LW'(LEAVES - 1);
                  state <= S_BUILD_RD;
                end
              end
              OP_BUILD: begin
                bi <= LW'(LEAVES - 1);
                state <= S_BUILD_RD;
              end
              OP_QUERY: begin
                lo <= op_a;
                hi <= op_b;
                empty_q <= op_flag;
                acc <= NEG;
                va <= 1'b0;
                vb <= 1'b0;
                state <= S_CLIMB;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_BUILD_RD: begin
          state <= S_BUILD_WR;
        end
        S_BUILD_WR: begin
          if (bi == LW'(1)) begin
            state <= S_IDLE;
          end else begin
            bi <= bi - LW'(1);
            state <= S_BUILD_RD;
          end
        end
        S_CLIMB: begin
          // fold in last level's reads while issuing this level's
          acc <= acc_next;
          va <= climbing && lo[0];
          vb <= climbing && hi[0];
          lo <= (lo + AW'(lo[0])) >> 1;
          hi <= hi >> 1;
          if (!climbing) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            result.valid <= 1'b1;
            result.max_value <= VALUE_W'(acc);
            result.empty_res <= empty_q;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/segment_tree_range_max.sv @@
// top level of the range maximum segment tree
//
//   channel  dir  fields                              transfer
//   item     in   cmd, value, last, left, right       valid && ready
//   result   out  max_value, empty_res                valid && ready
//
// query: the climb reads two nodes per level
// load: a load with last also builds the inner nodes, one node at a time (S_BUILD_RD, then S_BUILD_WR)
// clear: sweeps every node of the node memory; the same sweep runs after rst
// item.ready stays low until the sweep after rst ends
// the op queue lets commands land while the back end builds, climbs or waits on result.ready
module segment_tree_range_max #(
  parameter int LEAVES = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  strm_item_if.sink item,
  strm_result_if.source result
);
  import strm_pkg::*;

  localparam int OP_W = op_width(LEAVES, VALUE_WIDTH);

  logic init_done;
  logic fq_valid;
  logic fq_ready;
  logic [OP_W-1:0] fq_data;
  logic bq_valid;
  logic bq_ready;
  logic [OP_W-1:0] bq_data;

  strm_front #(
    .LEAVES(LEAVES),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .item(item),
    .init_done(init_done),
    .q_valid(fq_valid),
    .q_ready(fq_ready),
    .q_data(fq_data)
  );

  strm_queue #(
    .WIDTH(OP_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data(fq_data),
    .pop_valid(bq_valid),
    .pop_ready(bq_ready),
    .pop_data(bq_data)
  );

  strm_back #(
    .LEAVES(LEAVES),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(bq_valid),
    .q_ready(bq_ready),
    .q_data(bq_data),
    .init_done(init_done),
    .result(result)
  );

endmodule

@@ tb/tb_segment_tree_range_max.sv @@
// self-checking testbench for the range maximum segment tree: directed rows then random sequences
module tb_segment_tree_range_max;
  import strm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEAVES = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] NEG_LIMIT = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] POS_LIMIT = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam int NUM_ROWS = 23;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic signed [VALUE_W-1:0] value;
    logic last;
    logic [INDEX_W-1:0] left;
    logic [INDEX_W-1:0] right;
  } tree_cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] max_value;
    logic empty_res;
  } max_result_t;

  typedef struct packed {
    tree_cmd_t c;
    logic typed;
    max_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  strm_item_if item_ch ();
  strm_result_if result_ch ();

  segment_tree_range_max #(
    .LEAVES(LEAVES),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch)
  );

  always #10 clk = ~clk;

  logic signed [VALUE_W-1:0] tree_nodes [0:2*LEAVES-1];
  int unsigned fill_pos;
  max_result_t pending_maxima [$];
  int mismatches = 0;
  int items_sent = 0;
  bit quiet_sender = 1'b0;
  int hold_asks = 0;

  function automatic void reset_tree();
    for (int i = 0; i < 2 * LEAVES; i++) tree_nodes[i] = NEG_LIMIT;
    fill_pos = 0;
  endfunction

  function automatic bit apply_tree_cmd(input tree_cmd_t c, output max_result_t res);
    int unsigned lo;
    int unsigned hi;
    logic signed [VALUE_W-1:0] acc;
    res = '{NEG_LIMIT, 1'b1};
    case (c.cmd)
      CMD_CLEAR: begin
        reset_tree();
        return 1'b0;
      end
      CMD_LOAD: begin
        if (fill_pos < LEAVES) begin
          tree_nodes[LEAVES + fill_pos] = c.value;
          fill_pos++;
        end
        if (c.last) begin
          for (int i = LEAVES - 1; i > 0; i--)
            tree_nodes[i] = (tree_nodes[2*i] > tree_nodes[2*i+1]) ? tree_nodes[2*i] :
                            tree_nodes[2*i+1];
        end
        return 1'b0;
      end
      CMD_QUERY: begin
        if (c.left < c.right) begin
          lo = (c.left > LEAVES) ? LEAVES : c.left;
          hi = (c.right > LEAVES) ? LEAVES : c.right;
          lo += LEAVES;
          hi += LEAVES;
          acc = NEG_LIMIT;
          while (lo < hi) begin
            if (lo[0]) begin
              if (tree_nodes[lo] > acc) acc = tree_nodes[lo];
              lo++;
            end
            if (hi[0]) begin
              hi--;
              if (tree_nodes[hi] > acc) acc = tree_nodes[hi];
            end
            lo = lo >> 1;
            hi = hi >> 1;
          end
          res = '{acc, 1'b0};
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return NEG_LIMIT;
        1: return POS_LIMIT;
        2: return -1;
        default: return 0;
      endcase
    end
    if (r < 50) return $signed($urandom_range(0, 200)) - 100;
    return $urandom();
  endfunction

  function automatic tree_cmd_t rand_query();
    tree_cmd_t c;
    int unsigned p;
    int r;
    c.cmd = CMD_QUERY;
    c.value = $urandom();
    c.last = 1'($urandom_range(0, 1));
    p = (fill_pos == 0) ? 1 : fill_pos;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      c.left = INDEX_W'($urandom_range(0, p - 1));
      c.right = INDEX_W'($urandom_range(c.left + 1, p));
    end else if (r < 75) begin
      c.left = INDEX_W'($urandom_range(0, 2047));
      c.right = INDEX_W'($urandom_range(0, c.left));
    end else if (r < 90) begin
      c.left = INDEX_W'($urandom_range(0, 2047));
      c.right = INDEX_W'($urandom_range(0, 2047));
    end else begin
      c.left = INDEX_W'($urandom_range(0, LEAVES));
      c.right = INDEX_W'($urandom_range(0, LEAVES));
    end
    return c;
  endfunction

  function automatic tree_cmd_t make_cmd(input logic [CMD_W-1:0] cmd, input logic last);
    tree_cmd_t c;
    c.cmd = cmd;
    c.value = rand_value();
    c.last = last;
    c.left = INDEX_W'($urandom_range(0, 2047));
    c.right = INDEX_W'($urandom_range(0, 2047));
    return c;
  endfunction

  task automatic send_cmd(input tree_cmd_t c, input bit typed, input max_result_t want);
    int gap;
    max_result_t res;
    gap = quiet_sender ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.cmd <= c.cmd;
    item_ch.value <= c.value;
    item_ch.last <= c.last;
    item_ch.left <= c.left;
    item_ch.right <= c.right;
    do @(posedge clk); while (!item_ch.ready);
    if (apply_tree_cmd(c, res))
      pending_maxima.insert(pending_maxima.size(), typed ? want : res);
    if (c.cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_maxima.size() != 0);
  endtask

  task automatic load_run(input int n, input bit finish);
    for (int i = 0; i < n; i++)
      send_cmd(make_cmd(CMD_LOAD, finish && (i == n - 1)), 1'b0, '0);
  endtask

  task automatic query_run(input int n);
    for (int i = 0; i < n; i++) send_cmd(rand_query(), 1'b0, '0);
  endtask

  // result side: random stalls, calm stretches, and long holds on request
  initial begin
    int stall;
    int calm;
    int hold_done;
    stall = 0;
    calm = 0;
    hold_done = 0;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        stall--;
      end else begin
        result_ch.ready <= 1'b1;
        if (calm > 0) calm--;
        else if ($urandom_range(0, 199) == 0) calm = $urandom_range(50, 300);
        else if ($urandom_range(0, 5) == 0) stall = pick_gap();
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    max_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_maxima.size() == 0) begin
        $display("%0t: unexpected result max_value %0d empty_res %0b", $time,
                 result_ch.max_value, result_ch.empty_res);
        mismatches++;
      end else begin
        want = pending_maxima.pop_front();
        if (result_ch.max_value !== want.max_value) begin
          $display("%0t: max_value expected %0d actual %0d", $time, want.max_value,
                   result_ch.max_value);
          mismatches++;
        end
        if (result_ch.empty_res !== want.empty_res) begin
          $display("%0t: empty_res expected %0b actual %0b", $time, want.empty_res,
                   result_ch.empty_res);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", pending_maxima.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    directed_row_t rows [NUM_ROWS];
    int seq_idx;
    int r;
    item_ch.valid <= 1'b0;
    item_ch.cmd <= CMD_CLEAR;
    item_ch.value <= '0;
    item_ch.last <= 1'b0;
    item_ch.left <= '0;
    item_ch.right <= '0;
    reset_tree();
    rows = '{
      '{'{CMD_QUERY, 32'sd0, 1'b0, 11'd0, 11'd1024}, 1'b1, '{NEG_LIMIT, 1'b0}},
      '{'{CMD_QUERY, -32'sd1, 1'b1, 11'd5, 11'd5}, 1'b1, '{NEG_LIMIT, 1'b1}},
      '{'{CMD_QUERY, 32'sd0, 1'b0, 11'd2047, 11'd0}, 1'b1, '{NEG_LIMIT, 1'b1}},
      '{'{CMD_QUERY, 32'sd0, 1'b1, 11'd1024, 11'd2047}, 1'b1, '{NEG_LIMIT, 1'b0}},
      '{'{CMD_LOAD, POS_LIMIT, 1'b0, 11'd0, 11'd0}, 1'b0, '0},
      '{'{CMD_LOAD, NEG_LIMIT, 1'b0, 11'd2047, 11'd2047}, 1'b0, '0},
      '{'{CMD_LOAD, -32'sd1, 1'b0, 11'd0, 11'd0}, 1'b0, '0},
      '{'{CMD_LOAD, 32'sd0, 1'b0, 11'd0, 11'd0}, 1'b0, '0},
      '{'{CMD_LOAD, 32'sd1, 1'b1, 11'd0, 11'd0}, 1'b0, '0},
      '{'{CMD_QUERY, 32'sd0, 1'b0, 11'd0, 11'd5}, 1'b1, '{POS_LIMIT, 1'b0}},
      '{'{CMD_QUERY, 32'sd0, 1'b0, 11'd1, 11'd5}, 1'b0, '0},
      '{'{CMD_QUERY, 32'sd0, 1'b0, 11'd1, 11'd2}, 1'b0, '0},
      '{'{CMD_QUERY, 32'sd0, 1'b0, 11'd2, 11'd1024}, 1'b0, '0},
      '{'{CMD_QUERY, 32'sd0, 1'b0, 11'd3, 11'd2047}, 1'b0, '0},
      '{'{CMD_UNUSED, -32'sd1, 1'b1, 11'd2047, 11'd2047}, 1'b0, '0},
      '{'{CMD_LOAD, 32'sd1000, 1'b0, 11'd0, 11'd0}, 1'b0, '0},
      '{'{CMD_QUERY, 32'sd0, 1'b0, 11'd0, 11'd1024}, 1'b0, '0},
      '{'{CMD_QUERY, 32'sd0, 1'b0, 11'd5, 11'd6}, 1'b0, '0},
      '{'{CMD_LOAD, 32'sd5, 1'b1, 11'd0, 11'd0}, 1'b0, '0},
      '{'{CMD_QUERY, 32'sd0, 1'b0, 11'd0, 11'd1024}, 1'b0, '0},
      '{'{CMD_CLEAR, 32'sd0, 1'b0, 11'd0, 11'd0}, 1'b0, '0},
      '{'{CMD_QUERY, 32'sd0, 1'b0, 11'd0, 11'd2}, 1'b1, '{NEG_LIMIT, 1'b0}},
      '{'{CMD_QUERY, 32'sd0, 1'b0, 11'd0, 11'd0}, 1'b1, '{NEG_LIMIT, 1'b1}}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) send_cmd(rows[i].c, rows[i].typed, rows[i].want);

    seq_idx = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      quiet_sender = ($urandom_range(0, 4) == 0);
      if (seq_idx == 3) begin
        // long result hold while queries keep coming
        quiet_sender = 1'b1;
        hold_asks++;
        query_run(40);
      end else if (seq_idx == 5) begin
        wait_drained();
        query_run(5);
      end else if (seq_idx == 8) begin
        // fill every leaf, then overflow loads that are dropped
        send_cmd(make_cmd(CMD_CLEAR, 1'($urandom_range(0, 1))), 1'b0, '0);
        load_run(LEAVES + 2, 1'b1);
        query_run(20);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          if ($urandom_range(0, 4) != 0)
            send_cmd(make_cmd(CMD_CLEAR, 1'($urandom_range(0, 1))), 1'b0, '0);
          r = $urandom_range(0, 99);
          load_run((r < 80) ? $urandom_range(1, 40) :
                   (r < 95) ? $urandom_range(41, 200) : $urandom_range(201, 400), 1'b1);
          query_run($urandom_range(3, 15));
          if ($urandom_range(0, 2) == 0) begin
            load_run($urandom_range(1, 4), 1'b0);
            query_run($urandom_range(2, 6));
            if ($urandom_range(0, 1) == 0) begin
              load_run(1, 1'b1);
              query_run($urandom_range(2, 6));
            end
          end
        end else if (r < 85) begin
          query_run($urandom_range(3, 12));
        end else begin
          repeat ($urandom_range(1, 4))
            send_cmd(make_cmd(CMD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1))),
                     1'b0, '0);
        end
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
      seq_idx++;
    end

    quiet_sender = 1'b0;
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_maxima.size() != 0);
    repeat (2 * LEAVES + 64) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
